// ===== rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned CAPACITY_DEF    = 256;
  localparam int unsigned KEY_BITS_DEF    = 32;
  localparam int unsigned HANDLE_BITS_DEF = 9;
  localparam int unsigned COUNT_BITS      = 9;
  localparam int unsigned STATUS_BITS     = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

endpackage

// ===== rtl/bmhq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/bmhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for heap insert (sift up) and extract (sift down).
// ----------------------------------------------------------------------------
module bmhq_ctrl import bmhq_pkg::*; #(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY+1),
  localparam int unsigned EW = KEY_BITS + HANDLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic                   req_mode,
  input  logic [KEY_BITS-1:0]    req_key,
  input  logic [HANDLE_BITS-1:0] req_handle,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [KEY_BITS-1:0]    res_key,
  output logic [HANDLE_BITS-1:0] res_handle,
  output status_t                res_status,
  output logic [CW-1:0]          res_count,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_addr,
  output logic [EW-1:0]          mem_wdata,
  input  logic [EW-1:0]          mem_rdata
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_UPRD  = 8'b0000_0010,
    S_UPCMP = 8'b0000_0100,
    S_XROOT = 8'b0000_1000,
    S_XLAST = 8'b0001_0000,
    S_DNL   = 8'b0010_0000,
    S_DNR   = 8'b0100_0000,
    S_DNCMP = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [EW-1:0]        ent_r, ent_nxt;    // entry being moved
  logic [EW-1:0]        pick_r, pick_nxt;  // best child so far
  logic [CW-1:0]        pidx_r, pidx_nxt;
  logic                 has_pick_r, has_pick_nxt;
  logic                 ov_r, ov_nxt;
  logic [KEY_BITS-1:0]  rk_r, rk_nxt;
  logic [HANDLE_BITS-1:0] rh_r, rh_nxt;
  status_t              rs_r, rs_nxt;
  logic [CW-1:0]        rc_r, rc_nxt;

  logic [CW:0]          lc, rcx;
  logic [CW-1:0]        parent;
  logic [KEY_BITS-1:0]  ent_key, rd_key, pick_key;

  assign ent_key  = ent_r[EW-1 -: KEY_BITS];
  assign rd_key   = mem_rdata[EW-1 -: KEY_BITS];
  assign pick_key = pick_r[EW-1 -: KEY_BITS];
  assign parent   = (pos_r - CW'(1)) >> 1;
  assign lc       = {pos_r, 1'b1};
  assign rcx      = {pos_r, 1'b0} + (CW+1)'(2);

  assign req_ready  = (state_r == S_IDLE) && !ov_r;
  assign res_valid  = ov_r;
  assign res_key    = rk_r;
  assign res_handle = rh_r;
  assign res_status = rs_r;
  assign res_count  = rc_r;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; pos_nxt = pos_r; ent_nxt = ent_r;
    pick_nxt = pick_r; pidx_nxt = pidx_r; has_pick_nxt = has_pick_r;
    ov_nxt = ov_r && !res_ready;
    rk_nxt = rk_r; rh_nxt = rh_r; rs_nxt = rs_r; rc_nxt = rc_r;
    mem_we = 1'b0; mem_addr = '0; mem_wdata = ent_r;
    case (state_r)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          rk_nxt = '0; rh_nxt = '0; rs_nxt = ST_OK;
          if (req_mode == MODE_INSERT) begin
            if (cnt_r == CW'(CAPACITY)) begin
              rs_nxt = ST_FULL; rc_nxt = cnt_r; ov_nxt = 1'b1;
            end else begin
              ent_nxt = {req_key, req_handle};
              pos_nxt = cnt_r;
              state_nxt = S_UPRD;
            end
          end else if (cnt_r == '0) begin
            rs_nxt = ST_EMPTY; rc_nxt = '0; ov_nxt = 1'b1;
          end else begin
            mem_addr = '0;
            cnt_nxt = cnt_r - CW'(1);
            state_nxt = S_XROOT;
          end
        end
      end
      S_UPRD: begin
        if (pos_r == '0) begin
          mem_we = 1'b1; mem_addr = '0;
          cnt_nxt = cnt_r + CW'(1); rc_nxt = cnt_r + CW'(1);
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          mem_addr = parent[AW-1:0];
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        mem_addr = pos_r[AW-1:0];
        if (ent_key < rd_key) begin
          // move parent down, continue upward
          mem_we = 1'b1; mem_wdata = mem_rdata;
          pos_nxt = parent; state_nxt = S_UPRD;
        end else begin
          mem_we = 1'b1;
          cnt_nxt = cnt_r + CW'(1); rc_nxt = cnt_r + CW'(1);
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_XROOT: begin
        rk_nxt = rd_key; rh_nxt = mem_rdata[HANDLE_BITS-1:0];
        if (cnt_r == '0) begin
          rc_nxt = '0; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          mem_addr = cnt_r[AW-1:0];
          state_nxt = S_XLAST;
        end
      end
      S_XLAST: begin
        ent_nxt = mem_rdata; pos_nxt = '0; state_nxt = S_DNL;
      end
      S_DNL: begin
        // sift down: fetch left child, or write the entry here if it has none
        has_pick_nxt = 1'b0;
        if (lc < (CW+1)'(cnt_r)) begin
          mem_addr = lc[AW-1:0];
          state_nxt = S_DNR;
        end else begin
          mem_we = 1'b1; mem_addr = pos_r[AW-1:0];
          rc_nxt = cnt_r; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_DNR: begin
        if (rd_key < ent_key) begin
          has_pick_nxt = 1'b1; pick_nxt = mem_rdata; pidx_nxt = lc[CW-1:0];
        end
        if (rcx < (CW+1)'(cnt_r)) begin
          mem_addr = rcx[AW-1:0];
          state_nxt = S_DNCMP;
        end else if (rd_key < ent_key) begin
          mem_we = 1'b1; mem_addr = pos_r[AW-1:0]; mem_wdata = mem_rdata;
          pos_nxt = lc[CW-1:0]; state_nxt = S_DNL;
        end else begin
          mem_we = 1'b1; mem_addr = pos_r[AW-1:0];
          rc_nxt = cnt_r; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_DNCMP: begin
        mem_addr = pos_r[AW-1:0];
        if (rd_key < (has_pick_r ? pick_key : ent_key)) begin
          mem_we = 1'b1; mem_wdata = mem_rdata;
          pos_nxt = rcx[CW-1:0]; state_nxt = S_DNL;
        end else if (has_pick_r) begin
          mem_we = 1'b1; mem_wdata = pick_r;
          pos_nxt = pidx_r; state_nxt = S_DNL;
        end else begin
          mem_we = 1'b1;
          rc_nxt = cnt_r; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
    pos_r <= pos_nxt; ent_r <= ent_nxt; pick_r <= pick_nxt; pidx_r <= pidx_nxt;
    has_pick_r <= has_pick_nxt; rk_r <= rk_nxt; rh_r <= rh_nxt;
    rs_r <= rs_nxt; rc_r <= rc_nxt;
  end

endmodule

// ===== rtl/binary_min_heap_queue_top.sv =====
// Flagged requests (insert when full, extract when empty) are answered from idle;
// an insert reads and compares the parent per level climbed, and an extract reads
// the root, then if entries remain the last entry, then both children per level.
// One request at a time, the next taken the cycle after the result is taken.
// Reset (rst_n low, synchronous) empties the heap; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Min-heap priority queue with insert and extract-min requests.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top import bmhq_pkg::*; #(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int unsigned IW = ((1 + KEY_BITS + HANDLE_BITS + 7) / 8) * 8,
  localparam int unsigned OW = ((KEY_BITS + HANDLE_BITS + STATUS_BITS + COUNT_BITS + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [IW-1:0] in_tdata,   // mode, key, handle
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [OW-1:0] out_tdata   // out_key, out_handle, status, count
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY+1);
  localparam int unsigned EW = KEY_BITS + HANDLE_BITS;

  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [EW-1:0]          mem_wdata, mem_rdata;
  logic [KEY_BITS-1:0]    res_key;
  logic [HANDLE_BITS-1:0] res_handle;
  status_t                res_status;
  logic [CW-1:0]          res_count;

  bmhq_ctrl #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)) u_ctrl (
    .clk, .rst_n,
    .req_valid (in_tvalid), .req_ready (in_tready),
    .req_mode  (in_tdata[0]),
    .req_key   (in_tdata[KEY_BITS:1]),
    .req_handle(in_tdata[KEY_BITS+HANDLE_BITS:KEY_BITS+1]),
    .res_valid (out_tvalid), .res_ready (out_tready),
    .res_key, .res_handle, .res_status, .res_count,
    .mem_we, .mem_addr, .mem_wdata, .mem_rdata
  );

  bmhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk, .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  assign out_tdata = OW'({COUNT_BITS'(res_count), res_status, res_handle, res_key});

endmodule

// ===== rtl/bmhq_checker.sv =====
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level assertions for the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_checker import bmhq_pkg::*; #(
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int unsigned OW = ((KEY_BITS + HANDLE_BITS + STATUS_BITS + COUNT_BITS + 7) / 8) * 8,
  localparam int unsigned ST_LO  = KEY_BITS + HANDLE_BITS,
  localparam int unsigned CNT_LO = ST_LO + STATUS_BITS
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [OW-1:0] out_tdata
);

  logic [STATUS_BITS-1:0] st;
  assign st = out_tdata[ST_LO +: STATUS_BITS];

  // one request in flight: no new request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("request taken with result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed");

  // flagged results carry zero key and handle
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_OK |-> out_tdata[ST_LO-1:0] == '0)
    else $error("flagged result has payload");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st == ST_OK || st == ST_EMPTY || st == ST_FULL))
    else $error("bad status");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_EMPTY |-> out_tdata[CNT_LO +: COUNT_BITS] == '0)
    else $error("empty flag with nonzero count");

endmodule

bind binary_min_heap_queue_top bmhq_checker #(
  .KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)
) u_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top testbench
// Drives insert and extract-min requests through the stream ports, keeps its
// own min-heap model and checks every result field against it, under several
// sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench import bmhq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = CAPACITY_DEF;
  localparam int unsigned KB  = KEY_BITS_DEF;
  localparam int unsigned HB  = HANDLE_BITS_DEF;
  localparam int unsigned IW  = ((1 + KB + HB + 7) / 8) * 8;
  localparam int unsigned OW  = ((KB + HB + STATUS_BITS + COUNT_BITS + 7) / 8) * 8;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    status_t               status;
    logic [HB-1:0]         handle;
    logic [KB-1:0]         key;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OW-1:0] out_tdata;

  // heap model
  logic [KB-1:0] mdl_key [CAP];
  logic [HB-1:0] mdl_hdl [CAP];
  int unsigned   mdl_count;

  heap_result_t expected_results [$];
  int unsigned  error_count, result_count, insert_count, extract_count, flag_count;
  int unsigned  send_idle_pct, recv_stall_pct, idle_cycles;

  binary_min_heap_queue_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  function automatic heap_result_t heap_apply(logic mode, logic [KB-1:0] k, logic [HB-1:0] h);
    heap_result_t r;
    int unsigned pos, parent, pick, lc, rc;
    logic [KB-1:0] tk;
    logic [HB-1:0] th;
    r = '0;
    r.status = ST_OK;
    if (mode == MODE_INSERT) begin
      if (mdl_count >= CAP) begin
        r.status = ST_FULL;
      end else begin
        pos = mdl_count;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!(k < mdl_key[parent])) break;
          mdl_key[pos] = mdl_key[parent];
          mdl_hdl[pos] = mdl_hdl[parent];
          pos = parent;
        end
        mdl_key[pos] = k;
        mdl_hdl[pos] = h;
        mdl_count++;
      end
    end else if (mdl_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.key = mdl_key[0];
      r.handle = mdl_hdl[0];
      mdl_count--;
      if (mdl_count > 0) begin
        mdl_key[0] = mdl_key[mdl_count];
        mdl_hdl[0] = mdl_hdl[mdl_count];
        pos = 0;
        forever begin
          pick = pos;
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          if (lc < mdl_count && mdl_key[lc] < mdl_key[pick]) pick = lc;
          if (rc < mdl_count && mdl_key[rc] < mdl_key[pick]) pick = rc;
          if (pick == pos) break;
          tk = mdl_key[pick]; th = mdl_hdl[pick];
          mdl_key[pick] = mdl_key[pos]; mdl_hdl[pick] = mdl_hdl[pos];
          mdl_key[pos] = tk; mdl_hdl[pos] = th;
          pos = pick;
        end
      end
    end
    r.count = mdl_count[COUNT_BITS-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [KB-1:0] got, logic [KB-1:0] want);
    $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Send one request; idle gaps before it follow the current sender pattern.
  // Valid stays high after acceptance until the next call decides on a gap.
  task automatic send_request(logic mode, logic [KB-1:0] k, logic [HB-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IW'({h, k, mode});
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(heap_apply(mode, k, h));
    if (mode == MODE_INSERT) insert_count++; else extract_count++;
    @(negedge clk);
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    heap_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = heap_result_t'(out_tdata[KB+HB+STATUS_BITS+COUNT_BITS-1:0]);
      result_count++;
      if (expected_results.size() == 0) begin
        $display("ERROR at %0t: result with no request outstanding", $realtime);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (want.status != ST_OK) flag_count++;
        if (got.key != want.key) report_mismatch("out_key", got.key, want.key);
        if (got.handle != want.handle) report_mismatch("out_handle", KB'(got.handle), KB'(want.handle));
        if (got.status != want.status) report_mismatch("status", KB'(got.status), KB'(want.status));
        if (got.count != want.count) report_mismatch("count", KB'(got.count), KB'(want.count));
      end
    end
  end

  // Watchdog on cycles with no request or result accepted
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("binary_min_heap_queue_top regression: fail");
      $finish;
    end
  end

  function automatic logic [KB-1:0] rand_key();
    case ($urandom_range(3))
      0: rand_key = KB'($urandom_range(7));
      1: rand_key = {KB{1'b1}} - KB'($urandom_range(3));
      default: rand_key = KB'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_request(MODE_EXTRACT, '1, '1);          // extract on empty heap
    send_request(MODE_INSERT, '1, '1);
    send_request(MODE_INSERT, '0, '0);
    send_request(MODE_INSERT, 32'd5, 9'd10);
    send_request(MODE_INSERT, 32'd5, 9'd11);     // equal keys
    send_request(MODE_INSERT, 32'd5, 9'd12);
    send_request(MODE_INSERT, 32'hAAAA_5555, 9'h155);
    send_request(MODE_INSERT, 32'h5555_AAAA, 9'h0AA);
    repeat (8) send_request(MODE_EXTRACT, '0, '0);
    send_request(MODE_EXTRACT, 32'h1234, 9'h1);
  endtask

  // Fill to capacity, try one more, then drain past empty.
  task automatic test_full_heap();
    repeat (CAP) send_request(MODE_INSERT, rand_key(), HB'($urandom()));
    send_request(MODE_INSERT, '1, '1);
    repeat (CAP + 1) send_request(MODE_EXTRACT, KB'($urandom()), HB'($urandom()));
  endtask

  task automatic test_random(int unsigned n);
    int unsigned bias;
    for (int unsigned i = 0; i < n; i++) begin
      bias = (i / 60) % 2 ? 35 : 65;   // alternate growing and shrinking phases
      send_request($urandom_range(99) < bias ? MODE_INSERT : MODE_EXTRACT,
                   rand_key(), HB'($urandom()));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_heap();
    test_random(130);
    send_idle_pct = 69;
    test_random(130);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    test_random(130);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    test_random(130);
    drain();
    $display("Covered %0d inserts and %0d extracts, %0d results, %0d flagged.",
             insert_count, extract_count, result_count, flag_count);
    $display("Idling patterns: none, sender 69%%, receiver 69%%, both 10%%.");
    if (error_count == 0) begin
      $display("binary_min_heap_queue_top regression: pass");
    end else begin
      $display("binary_min_heap_queue_top regression: fail");
    end
    $finish;
  end
endmodule
